@@ src/lfsh_pkg.sv @@
// shared types, constants and tables for the leader follow speed and heading core
package lfsh_pkg;

   localparam int ANGLE_FRACTION_BITS = 12;
   localparam int CORDIC_STEPS        = 14;
   localparam int ZW  = 34;                       // q30 angle width
   localparam int CW  = 38;                       // cordic x/y width
   localparam int DVW = 27;                       // dividend width of the speed division
   localparam int AZ_SHIFT = 30 - ANGLE_FRACTION_BITS;

   localparam logic signed [ZW-1:0] Q30_PI       = 34'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_NEG_PI   = -34'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_HALF_PI  = 34'sd1686629713;
   localparam logic signed [ZW-1:0] Q30_NEG_HALF = -34'sd1686629713;
   localparam logic signed [ZW-1:0] Q30_TWO_PI   = 34'sd6746518852;
   localparam logic signed [ZW-1:0] ANGLE_MAX    = 34'sd16383;
   localparam logic signed [ZW-1:0] ANGLE_MIN    = -34'sd16383;
   localparam logic signed [ZW-1:0] ROUND_HALF   = ZW'(64'sd1 <<< (AZ_SHIFT - 1));
   localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

   typedef enum logic [2:0] {
      OP_BEGIN  = 3'd0,
      OP_OBJECT = 3'd1,
      OP_SURF   = 3'd2,
      OP_END    = 3'd3,
      OP_SPEED  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CSR_LAT_LIMIT = 3'd0,
      CSR_LON_LIMIT = 3'd1,
      CSR_STEER_THR = 3'd2,
      CSR_TTC       = 3'd3,
      CSR_MAX_SPEED = 3'd4
   } csr_type;

   typedef enum logic {
      KIND_HEADING = 1'b0,
      KIND_SPEED   = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_OBJ_PREP, ST_SURF_PREP, ST_CORDIC, ST_OBJ_CHECK, ST_OBJ_MUL, ST_DIV,
      ST_SPEED, ST_SURF_ROUND, ST_SURF_SEL, ST_MEAS_MUL, ST_MEAS_DIV, ST_MEAS_OUT, ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   function automatic logic [29:0] atan_q30(input logic [3:0] idx);
      logic [29:0] v;
      case (idx)
         4'd0:  v = 30'd843314857;
         4'd1:  v = 30'd497837829;
         4'd2:  v = 30'd263043837;
         4'd3:  v = 30'd133525159;
         4'd4:  v = 30'd67021687;
         4'd5:  v = 30'd33543516;
         4'd6:  v = 30'd16775851;
         4'd7:  v = 30'd8388437;
         4'd8:  v = 30'd4194283;
         4'd9:  v = 30'd2097149;
         4'd10: v = 30'd1048576;
         4'd11: v = 30'd524288;
         4'd12: v = 30'd262144;
         4'd13: v = 30'd131072;
         4'd14: v = 30'd65536;
         4'd15: v = 30'd32768;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

@@ src/leader_follow_speed_and_heading_core.sv @@
// leader follow speed and heading core: top level with sequencer and state
// one request at a time; req_stall is high from acceptance until the sequencer is idle again
// object request: the sequencer waits on the cordic and, for a positive longitudinal distance, on the divider
// object beyond a limit: ends after the limit check; surface request: vectoring, rounding and selection
// begin: handled while idle; end: goes straight to emit; a result held by rsp_stall keeps the sequencer waiting
// synchronous active-high reset clears the persistent flags, headings, desired speed and loads csr defaults
module leader_follow_speed_and_heading_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic               req_expired,
   input  logic               req_is_leader,
   input  logic signed [14:0] req_object_azimuth,
   input  logic [15:0]        req_object_distance_cm,
   input  logic               req_four_edges,
   input  logic signed [15:0] req_left_x_cm,
   input  logic signed [15:0] req_left_y_cm,
   input  logic signed [15:0] req_right_x_cm,
   input  logic signed [15:0] req_right_y_cm,
   input  logic [15:0]        req_speed_kph_q8,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_command_kind,
   output logic signed [14:0] rsp_heading,
   output logic [15:0]        rsp_desired_speed_cms,
   output logic [12:0]        rsp_measured_speed_cms,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import lfsh_pkg::*;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] lat_limit_ff, lon_limit_ff, ttc_ff, max_speed_ff;
   logic [13:0] steer_thr_ff;

   // persistent state
   logic leader_ff, ignored_ff, stopped_ff, best_valid_ff;
   logic signed [14:0] prev_ff, best_ff;
   logic [15:0] desired_ff;

   // working registers
   logic signed [14:0] az_ff, angle_ff;
   logic [15:0] dist_ff, spd_ff;
   logic signed [ZW-1:0] zw_ff, base_ff;
   logic signed [16:0] sum_x_ff, sum_y_ff;
   logic signed [CW-1:0] lon_ff;
   logic flip_ff, surf_mode_ff, q_zero_ff;
   logic [23:0] mp_ff;
   logic [31:0] mr_ff;

   // pending result and output register
   logic pend_kind_ff;
   logic signed [14:0] pend_heading_ff;
   logic [15:0] pend_desired_ff;
   logic [12:0] pend_meas_ff;
   logic rsp_valid_ff, rsp_kind_ff;
   logic signed [14:0] rsp_heading_ff;
   logic [15:0] rsp_desired_ff;
   logic [12:0] rsp_meas_ff;

   logic req_acc, obj_go, surf_go, end_go, rsp_free, surf_zero, steer_go, lon_pos, over;
   logic signed [ZW-1:0] z_raw, z_wrap, z_fold, z_tot, z_rnd;
   logic signed [CW-1:0] cx_init, cy_init, cx, cy, lon, lat, lon_abs, lat_abs;
   logic signed [ZW-1:0] cz_init, cz;
   logic signed [17:0] x_abs, y_adj;
   logic [45:0] gain_prod;
   logic [42:0] speed_prod;
   logic [DVW-1:0] quot;
   logic [DVW-1:0] sp;
   logic [15:0] ttc_eff;
   logic [14:0] az_abs;
   logic signed [16:0] d_new, d_best;
   logic [16:0] d_new_abs, d_best_abs;
   logic cordic_done, div_done, div_start;
   cordic_cmd_type cordic_cmd;

   assign req_acc  = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign obj_go   = !ignored_ff && !stopped_ff && req_is_leader;
   assign surf_go  = !ignored_ff && req_four_edges;
   assign end_go   = !ignored_ff && !leader_ff && best_valid_ff;

   // datapath helpers
   always_comb begin
      z_raw  = ZW'(req_object_azimuth) <<< AZ_SHIFT;
      if (z_raw > Q30_PI)
         z_wrap = z_raw - Q30_TWO_PI;
      else if (z_raw < Q30_NEG_PI)
         z_wrap = z_raw + Q30_TWO_PI;
      else
         z_wrap = z_raw;
      if (zw_ff > Q30_HALF_PI)
         z_fold = zw_ff - Q30_PI;
      else if (zw_ff < Q30_NEG_HALF)
         z_fold = zw_ff + Q30_PI;
      else
         z_fold = zw_ff;
      gain_prod = 46'(dist_ff) * 46'(CORDIC_GAIN_Q30);
      surf_zero = (sum_x_ff == '0) && (sum_y_ff == '0);
      // left half-plane midpoints are turned by half a turn before vectoring
      x_abs = sum_x_ff[16] ? -18'(sum_x_ff) : 18'(sum_x_ff);
      y_adj = sum_x_ff[16] ? -18'(sum_y_ff) : 18'(sum_y_ff);
      if (surf_mode_ff) begin
         cx_init = CW'(x_abs) <<< 16;
         cy_init = CW'(y_adj) <<< 16;
         cz_init = '0;
      end else begin
         cx_init = signed'(CW'(gain_prod[45:14]));
         cy_init = '0;
         cz_init = z_fold;
      end
      lon     = flip_ff ? -cx : cx;
      lat     = flip_ff ? -cy : cy;
      lon_abs = lon[CW-1] ? -lon : lon;
      lat_abs = lat[CW-1] ? -lat : lat;
      over    = (lon_abs > signed'(CW'({lon_limit_ff, 16'b0}))) ||
                (lat_abs > signed'(CW'({lat_limit_ff, 16'b0})));
      lon_pos    = !lon_ff[CW-1] && (lon_ff != '0);
      speed_prod = 43'(lon_ff[32:0]) * 43'(10'd1000);
      ttc_eff    = (ttc_ff == '0) ? 16'd1 : ttc_ff;
      sp         = q_zero_ff ? '0 : quot;
      az_abs     = az_ff[14] ? 15'(-az_ff) : 15'(az_ff);
      steer_go   = az_abs < {1'b0, steer_thr_ff};
      z_tot      = cz + base_ff;
      z_rnd      = (z_tot + ROUND_HALF) >>> AZ_SHIFT;
      d_new      = 17'(prev_ff) - 17'(angle_ff);
      d_best     = 17'(prev_ff) - 17'(best_ff);
      d_new_abs  = d_new[16] ? 17'(-d_new) : 17'(d_new);
      d_best_abs = d_best[16] ? 17'(-d_best) : 17'(d_best);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_operation)
                  OP_OBJECT: state_in = obj_go ? ST_OBJ_PREP : ST_IDLE;
                  OP_SURF:   state_in = surf_go ? ST_SURF_PREP : ST_IDLE;
                  OP_END:    state_in = end_go ? ST_EMIT : ST_IDLE;
                  OP_SPEED:  state_in = ST_MEAS_MUL;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_OBJ_PREP:   state_in = ST_CORDIC;
         ST_SURF_PREP:  state_in = surf_zero ? ST_SURF_SEL : ST_CORDIC;
         ST_CORDIC: begin
            if (cordic_done)
               state_in = surf_mode_ff ? ST_SURF_ROUND : ST_OBJ_CHECK;
         end
         ST_OBJ_CHECK:  state_in = over ? ST_IDLE : ST_OBJ_MUL;
         ST_OBJ_MUL:    state_in = lon_pos ? ST_DIV : ST_SPEED;
         ST_DIV: begin
            if (div_done)
               state_in = ST_SPEED;
         end
         ST_SPEED:      state_in = steer_go ? ST_EMIT : ST_IDLE;
         ST_SURF_ROUND: state_in = ST_SURF_SEL;
         ST_SURF_SEL:   state_in = ST_IDLE;
         ST_MEAS_MUL:   state_in = ST_MEAS_DIV;
         ST_MEAS_DIV:   state_in = ST_MEAS_OUT;
         ST_MEAS_OUT:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free)
               state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall            = state_ff != ST_IDLE;
      cordic_cmd.start     = (state_ff == ST_OBJ_PREP) ||
                             ((state_ff == ST_SURF_PREP) && !surf_zero);
      cordic_cmd.vectoring = state_ff == ST_SURF_PREP;
      div_start            = (state_ff == ST_OBJ_MUL) && lon_pos;
   end

   lfsh_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cordic_cmd),
      .x_init (cx_init),
      .y_init (cy_init),
      .z_init (cz_init),
      .x_out  (cx),
      .y_out  (cy),
      .z_out  (cz),
      .done   (cordic_done)
   );

   lfsh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (speed_prod[42:16]),
      .divisor  (ttc_eff),
      .quotient (quot),
      .done     (div_done)
   );

   // control state, configuration and persistent flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lat_limit_ff  <= 16'd30000;
         lon_limit_ff  <= 16'd5000;
         steer_thr_ff  <= 14'd410;
         ttc_ff        <= 16'd10000;
         max_speed_ff  <= 16'd0;
         leader_ff     <= 1'b0;
         ignored_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         best_valid_ff <= 1'b0;
         prev_ff       <= '0;
         best_ff       <= '0;
         desired_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               CSR_LAT_LIMIT: lat_limit_ff <= csr_data;
               CSR_LON_LIMIT: lon_limit_ff <= csr_data;
               CSR_STEER_THR: steer_thr_ff <= csr_data[13:0];
               CSR_TTC:       ttc_ff       <= csr_data;
               CSR_MAX_SPEED: max_speed_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_acc) begin
            case (req_operation)
               OP_BEGIN: begin
                  leader_ff     <= 1'b0;
                  ignored_ff    <= req_expired;
                  stopped_ff    <= 1'b0;
                  best_valid_ff <= 1'b0;
               end
               OP_END: begin
                  if (end_go)
                     prev_ff <= best_ff;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_OBJ_CHECK && over)
            stopped_ff <= 1'b1;
         if (state_ff == ST_SPEED) begin
            desired_ff <= (sp > DVW'(max_speed_ff)) ? max_speed_ff : sp[15:0];
            if (steer_go) begin
               leader_ff <= 1'b1;
               prev_ff   <= az_ff;
            end
         end
         if (state_ff == ST_SURF_SEL &&
             (!best_valid_ff || d_new_abs < d_best_abs)) begin
            best_ff       <= angle_ff;
            best_valid_ff <= 1'b1;
         end
         if (state_ff == ST_EMIT && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_acc) begin
         az_ff    <= req_object_azimuth;
         dist_ff  <= req_object_distance_cm;
         zw_ff    <= z_wrap;
         sum_x_ff <= 17'(req_left_x_cm) + 17'(req_right_x_cm);
         sum_y_ff <= 17'(req_left_y_cm) + 17'(req_right_y_cm);
         spd_ff   <= req_speed_kph_q8;
         // the cordic start values depend on the mode, so it is known before the prep state
         surf_mode_ff    <= req_operation == OP_SURF;
         pend_kind_ff    <= KIND_HEADING;
         pend_heading_ff <= best_ff;
         pend_desired_ff <= '0;
         pend_meas_ff    <= '0;
      end
      case (state_ff)
         ST_OBJ_PREP: begin
            flip_ff      <= (zw_ff > Q30_HALF_PI) || (zw_ff < Q30_NEG_HALF);
         end
         ST_SURF_PREP: begin
            flip_ff      <= 1'b0;
            angle_ff     <= '0;
            if (!sum_x_ff[16])
               base_ff <= '0;
            else
               base_ff <= sum_y_ff[16] ? Q30_NEG_PI : Q30_PI;
         end
         ST_OBJ_CHECK: lon_ff <= lon;
         ST_OBJ_MUL:   q_zero_ff <= !lon_pos;
         ST_SPEED: begin
            pend_kind_ff    <= KIND_HEADING;
            pend_heading_ff <= az_ff;
            pend_desired_ff <= '0;
            pend_meas_ff    <= '0;
         end
         ST_SURF_ROUND: begin
            if (z_rnd > ANGLE_MAX)
               angle_ff <= 15'(ANGLE_MAX);
            else if (z_rnd < ANGLE_MIN)
               angle_ff <= 15'(ANGLE_MIN);
            else
               angle_ff <= 15'(z_rnd);
         end
         // speed / 3.6 as (v*125 + 576) / 1152, the divide by 9 by reciprocal
         ST_MEAS_MUL: mp_ff <= 24'(spd_ff) * 24'd125 + 24'd576;
         ST_MEAS_DIV: mr_ff <= 32'(mp_ff[23:7]) * 32'd58255;
         ST_MEAS_OUT: begin
            pend_kind_ff    <= KIND_SPEED;
            pend_heading_ff <= '0;
            pend_desired_ff <= desired_ff;
            pend_meas_ff    <= mr_ff[31:19];
         end
         default: ;
      endcase
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_kind_ff    <= pend_kind_ff;
         rsp_heading_ff <= pend_heading_ff;
         rsp_desired_ff <= pend_desired_ff;
         rsp_meas_ff    <= pend_meas_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_command_kind       = rsp_kind_ff;
   assign rsp_heading            = rsp_heading_ff;
   assign rsp_desired_speed_cms  = rsp_desired_ff;
   assign rsp_measured_speed_cms = rsp_meas_ff;

`ifndef SYNTHESIS
   a_cordic_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_CORDIC) else $error("cordic finished outside its wait");
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("divider finished outside its wait");
   a_speed_capped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPEED |=> desired_ff <= max_speed_ff)
      else $error("desired speed above cap");
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_EMIT)
      else $error("pending result dropped while output busy");
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_heading_ff != 15'sh4000) else $error("heading out of range");
`endif

endmodule

@@ src/lfsh_cordic.sv @@
// shared cordic unit, one micro-rotation per cycle, rotation or vectoring mode
module lfsh_cordic (
   input  logic                            clock,
   input  logic                            reset,
   input  lfsh_pkg::cordic_cmd_type        cmd,
   input  logic signed [lfsh_pkg::CW-1:0]  x_init,
   input  logic signed [lfsh_pkg::CW-1:0]  y_init,
   input  logic signed [lfsh_pkg::ZW-1:0]  z_init,
   output logic signed [lfsh_pkg::CW-1:0]  x_out,
   output logic signed [lfsh_pkg::CW-1:0]  y_out,
   output logic signed [lfsh_pkg::ZW-1:0]  z_out,
   output logic                            done
);
   import lfsh_pkg::*;

   localparam logic [3:0] LAST_STEP = 4'(CORDIC_STEPS - 1);

   logic signed [CW-1:0] x_ff, y_ff, xs, ys, x_in, y_in;
   logic signed [ZW-1:0] z_ff, z_in, at;
   logic [3:0] cnt_ff;
   logic busy_ff, vec_ff, done_ff, dir;

   always_comb begin
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      at  = signed'(ZW'(atan_q30(cnt_ff)));
      // rotate towards zero angle, or towards zero y when vectoring
      dir = vec_ff ? y_ff[CW-1] : !z_ff[ZW-1];
      x_in = dir ? x_ff - ys : x_ff + ys;
      y_in = dir ? y_ff + xs : y_ff - xs;
      z_in = dir ? z_ff - at : z_ff + at;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff   <= x_init;
         y_ff   <= y_init;
         z_ff   <= z_init;
         vec_ff <= cmd.vectoring;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

@@ src/lfsh_div.sv @@
// restoring divider, one quotient bit per cycle
module lfsh_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lfsh_pkg::DVW-1:0]     dividend,
   input  logic [15:0]                  divisor,
   output logic [lfsh_pkg::DVW-1:0]     quotient,
   output logic                         done
);
   import lfsh_pkg::*;

   localparam logic [4:0] LAST_STEP = 5'(DVW - 1);

   logic [DVW-1:0] q_ff;
   logic [15:0] rem_ff, div_ff, rem_in;
   logic [16:0] trial;
   logic [4:0] cnt_ff;
   logic busy_ff, done_ff, bit_in;

   always_comb begin
      trial  = {rem_ff, q_ff[DVW-1]};
      bit_in = trial >= {1'b0, div_ff};
      rem_in = bit_in ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend bits shift out of the top while quotient bits enter at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DVW-2:0], bit_in};
         rem_ff <= rem_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule
